// ===== design/int_key_linear_probe_map_defines.svh =====
// ---------------------------------------------------------------------------
// int_key_linear_probe_map assertion macros
// Shared property forms, sampled on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INT_KEY_LINEAR_PROBE_MAP_DEFINES_SVH
`define INT_KEY_LINEAR_PROBE_MAP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ILPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ILPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ilpm_pkg.sv =====
// ---------------------------------------------------------------------------
// ilpm_pkg
// Types and codes shared by the integer-key linear probe map.
// ---------------------------------------------------------------------------
package ilpm_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   read_value;
  } result_t;

endpackage

// ===== design/ilpm_if.sv =====
// ---------------------------------------------------------------------------
// ilpm_if
// Valid/ready channels for map requests and map results.
// ---------------------------------------------------------------------------
interface ilpm_in_if import ilpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [KEY_W-1:0]  lookup_key;
  logic [DATA_W-1:0] store_value;

  modport source (output valid, output operation, output lookup_key, output store_value,
                  input ready);
  modport sink   (input valid, input operation, input lookup_key, input store_value,
                  output ready);
endinterface

interface ilpm_out_if import ilpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

// ===== design/ilpm_home_unit.sv =====
// ---------------------------------------------------------------------------
// ilpm_home_unit
// Home slot of a key: key mod SLOT_COUNT, a mask for a power of two,
// else a reciprocal multiply followed by one compare and subtract.
// ---------------------------------------------------------------------------
module ilpm_home_unit import ilpm_pkg::*; #(
  parameter int SLOT_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [KEY_W-1:0]              key,
  output logic                          done,
  output logic [$clog2(SLOT_COUNT)-1:0] home
);

  localparam int SW = $clog2(SLOT_COUNT);

  if ((SLOT_COUNT & (SLOT_COUNT - 1)) == 0) begin : g_mask
    logic          done_r;
    logic [SW-1:0] home_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
      if (start) begin
        home_r <= key[SW-1:0];
      end
    end

    assign done = done_r;
    assign home = home_r;
  end else begin : g_recip
    // Quotient estimate is the true quotient or one less, so one subtract
    // brings the remainder below SLOT_COUNT.
    localparam int               RS    = KEY_W + SW - 1;
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << RS) / 64'(SLOT_COUNT));
    localparam logic [KEY_W-1:0] MOD_K = KEY_W'(SLOT_COUNT);

    logic [1:0]         stage_r;
    logic               done_r;
    logic [KEY_W-1:0]   key_c_r;
    logic [KEY_W-1:0]   quo_r;
    logic [KEY_W-1:0]   rem_r;
    logic [SW-1:0]      home_r;
    logic [2*KEY_W-1:0] prod;
    logic [KEY_W-1:0]   back;

    assign prod = (2*KEY_W)'(key) * (2*KEY_W)'(RECIP);
    assign back = quo_r * MOD_K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r <= '0;
        done_r  <= 1'b0;
      end else begin
        stage_r <= {stage_r[0], start};
        done_r  <= stage_r[1];
      end
      if (start) begin
        key_c_r <= key;
        quo_r   <= KEY_W'(prod >> RS);
      end
      if (stage_r[0]) begin
        rem_r <= key_c_r - back;
      end
      if (stage_r[1]) begin
        home_r <= (rem_r >= MOD_K) ? SW'(rem_r - MOD_K) : SW'(rem_r);
      end
    end

    assign done = done_r;
    assign home = home_r;
  end

endmodule

// ===== design/ilpm_out_reg.sv =====
// ---------------------------------------------------------------------------
// ilpm_out_reg
// Result register between the map engine and the result channel.
// ---------------------------------------------------------------------------
module ilpm_out_reg import ilpm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       enq_valid,
  output logic       enq_ready,
  input  result_t    enq_data,
  ilpm_out_if.source out_ch
);

  logic    full_r;
  result_t data_r;

  assign enq_ready = !full_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (enq_valid && enq_ready) begin
      full_r <= 1'b1;
    end else if (out_ch.ready) begin
      full_r <= 1'b0;
    end
    if (enq_valid && enq_ready) begin
      data_r <= enq_data;
    end
  end

  assign out_ch.valid      = full_r;
  assign out_ch.status     = data_r.status;
  assign out_ch.read_value = data_r.read_value;

endmodule

// ===== design/int_key_linear_probe_map.sv =====
// ---------------------------------------------------------------------------
// int_key_linear_probe_map
// Put/get key-value map: direct array for small keys, linear-probed table
// for the rest.
// ---------------------------------------------------------------------------
// After reset the block sweeps both memories over max(DIRECT_KEYS,
// SLOT_COUNT) addresses and holds in_ch.ready low meanwhile. It then serves
// one transaction at a time. A direct-key put writes the array in
// S_DISPATCH, a direct-key get reads it in S_DIRECT_RD; both then wait in
// S_RESULT for the result register. A table operation first computes the
// home slot (a mask when SLOT_COUNT is a power of two, else the reciprocal
// path), then probes successive slots, up to PROBE_LIMIT of them. A put to
// a table at half occupancy answers full without probing. The slot memory
// reads one slot per cycle, which sets the probe rate. The next request
// can be taken once its predecessor's result has entered the output register.
// ---------------------------------------------------------------------------
`include "int_key_linear_probe_map_defines.svh"

module int_key_linear_probe_map import ilpm_pkg::*; #(
  parameter int SLOT_COUNT  = 256,
  parameter int DIRECT_KEYS = 256,
  parameter int PROBE_LIMIT = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ilpm_in_if.sink    in_ch,
  ilpm_out_if.source out_ch
);

  localparam int SW     = $clog2(SLOT_COUNT);
  localparam int DW     = (DIRECT_KEYS > 1) ? $clog2(DIRECT_KEYS) : 1;
  localparam int PW     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int HALF   = SLOT_COUNT / 2;
  localparam int OW     = $clog2(HALF + 1);
  localparam int VW     = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int WORD_W = 1 + KEY_W + VW;
  localparam int V_BIT  = WORD_W - 1;
  localparam int CLR_N  = (DIRECT_KEYS > SLOT_COUNT) ? DIRECT_KEYS : SLOT_COUNT;
  localparam int CW     = $clog2(CLR_N);

  localparam logic [CW:0] DK_L = (CW+1)'(DIRECT_KEYS);
  localparam logic [CW:0] TS_L = (CW+1)'(SLOT_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_DIRECT_RD,
    S_HOME,
    S_PROBE,
    S_RESULT
  } state_t;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(SLOT_COUNT - 1)) ? '0 : s + SW'(1);
  endfunction

  state_t           state_r, state_nxt;
  logic             op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VW-1:0]    val_r, val_nxt;
  logic [CW-1:0]    clr_r, clr_nxt;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [SW-1:0]    next_r, next_nxt;
  logic [PW-1:0]    idx_r, idx_nxt;
  result_t          res_r, res_nxt;

  logic              dir_we;
  logic [DW-1:0]     dir_waddr;
  logic [VW-1:0]     dir_wdata;
  logic [DW-1:0]     dir_raddr;
  logic [VW-1:0]     dir_rd_r;
  logic              slot_we;
  logic [SW-1:0]     slot_waddr;
  logic [WORD_W-1:0] slot_wdata;
  logic [SW-1:0]     slot_raddr;
  logic [WORD_W-1:0] slot_rd_r;

  logic              home_start;
  logic              home_done;
  logic [SW-1:0]     home;
  logic              res_valid;
  logic              enq_ready;
  logic              occ_inc;
  logic              is_direct;
  logic              hit;
  logic              last;

  logic [VW-1:0]     dir_mem  [DIRECT_KEYS];
  logic [WORD_W-1:0] slot_mem [SLOT_COUNT];

  ilpm_home_unit #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (home_start),
    .key   (key_r),
    .done  (home_done),
    .home  (home)
  );

  ilpm_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (res_valid),
    .enq_ready (enq_ready),
    .enq_data  (res_r),
    .out_ch    (out_ch)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign is_direct   = key_r < KEY_W'(DIRECT_KEYS);
  assign hit         = slot_rd_r[V_BIT] && (slot_rd_r[VW +: KEY_W] == key_r);
  assign last        = (idx_r == PW'(PROBE_LIMIT - 1));

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    clr_nxt    = clr_r;
    occ_nxt    = occ_r;
    slot_nxt   = slot_r;
    next_nxt   = next_r;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    dir_we     = 1'b0;
    dir_waddr  = key_r[DW-1:0];
    dir_wdata  = val_r;
    dir_raddr  = key_r[DW-1:0];
    slot_we    = 1'b0;
    slot_waddr = slot_r;
    slot_wdata = {1'b1, key_r, val_r};
    slot_raddr = next_r;
    home_start = 1'b0;
    res_valid  = 1'b0;
    occ_inc    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        dir_we     = ({1'b0, clr_r} < DK_L);
        dir_waddr  = clr_r[DW-1:0];
        dir_wdata  = '0;
        slot_we    = ({1'b0, clr_r} < TS_L);
        slot_waddr = clr_r[SW-1:0];
        slot_wdata = '0;
        clr_nxt    = clr_r + CW'(1);
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          key_nxt   = in_ch.lookup_key;
          val_nxt   = in_ch.store_value[VW-1:0];
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_nxt.status     = ST_OK;
        res_nxt.read_value = '0;
        if (is_direct) begin
          if (op_r == OP_PUT) begin
            dir_we    = 1'b1;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_DIRECT_RD;
          end
        end else if ((op_r == OP_PUT) && (occ_r >= OW'(HALF))) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_RESULT;
        end else begin
          home_start = 1'b1;
          state_nxt  = S_HOME;
        end
      end
      S_DIRECT_RD: begin
        res_nxt.status     = (dir_rd_r != '0) ? ST_OK : ST_MISSING;
        res_nxt.read_value = DATA_W'(dir_rd_r);
        state_nxt          = S_RESULT;
      end
      S_HOME: begin
        slot_raddr = home;
        if (home_done) begin
          slot_nxt  = home;
          next_nxt  = slot_inc(home);
          idx_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        slot_nxt = next_r;
        next_nxt = slot_inc(next_r);
        idx_nxt  = idx_r + PW'(1);
        if (op_r == OP_PUT) begin
          if (!slot_rd_r[V_BIT]) begin
            slot_we   = 1'b1;
            occ_inc   = 1'b1;
            occ_nxt   = occ_r + OW'(1);
            state_nxt = S_RESULT;
          end else if (hit) begin
            slot_we   = 1'b1;
            state_nxt = S_RESULT;
          end else if (last) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_RESULT;
          end
        end else begin
          if (hit) begin
            res_nxt.read_value = DATA_W'(slot_rd_r[VW-1:0]);
            state_nxt          = S_RESULT;
          end else if (last) begin
            res_nxt.status = ST_MISSING;
            state_nxt      = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        res_valid = 1'b1;
        if (enq_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      occ_r   <= occ_nxt;
    end
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    slot_r <= slot_nxt;
    next_r <= next_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    dir_rd_r <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_r <= slot_mem[slot_raddr];
  end

  `ILPM_ASSERT_SAME(a_occ_bound, state_r != S_CLEAR, occ_r <= OW'(HALF), "occupancy above half")
  `ILPM_ASSERT_NEXT(a_new_key_counts, occ_inc, occ_r == $past(occ_r) + OW'(1), "count missed a new key")
  `ILPM_ASSERT_NEXT(a_result_holds, (state_r == S_RESULT) && !enq_ready, (state_r == S_RESULT) && $stable(res_r), "pending result lost")
  `ILPM_ASSERT_SAME(a_probe_range, state_r == S_PROBE, idx_r <= PW'(PROBE_LIMIT - 1), "probe past limit")

endmodule

// ===== bench/probe_map_checker.sv =====
// ----------------------------------------------------------------------------
// probe_map_checker
// Watches the request and result channels of the integer-key probe map, keeps
// its own copy of the direct array and the linear-probed table, and compares
// every result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module probe_map_checker import ilpm_pkg::*; #(
  parameter int TABLE_SLOTS  = 256,
  parameter int DIRECT_LIMIT = 256,
  parameter int PROBE_DEPTH  = 8
) (
  input  logic clk,
  input  logic rst_n,
  ilpm_in_if   in_mon,
  ilpm_out_if  out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   ok_count,
  output int   missing_count,
  output int   full_count,
  output int   table_fill_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DATA_W-1:0] direct_vals [DIRECT_LIMIT];
  logic              slot_used   [TABLE_SLOTS];
  logic [KEY_W-1:0]  slot_key    [TABLE_SLOTS];
  logic [DATA_W-1:0] slot_val    [TABLE_SLOTS];
  int                table_fill;
  result_t           expected_results [$];

  function automatic result_t predict_map_op(input logic op, input logic [KEY_W-1:0] key,
                                             input logic [DATA_W-1:0] val);
    result_t r;
    int      slot;
    r.status     = ST_OK;
    r.read_value = '0;
    slot         = int'(key % TABLE_SLOTS);
    if (key < DIRECT_LIMIT) begin
      if (op == OP_PUT) begin
        direct_vals[key] = val;
      end else begin
        r.read_value = direct_vals[key];
        if (direct_vals[key] == '0) r.status = ST_MISSING;
      end
    end else if (op == OP_PUT) begin
      r.status = ST_FULL;
      if (table_fill < TABLE_SLOTS / 2) begin
        for (int p = 0; p < PROBE_DEPTH; p++) begin
          if (!slot_used[slot]) begin
            slot_used[slot] = 1'b1;
            slot_key[slot]  = key;
            slot_val[slot]  = val;
            table_fill++;
            r.status = ST_OK;
            break;
          end
          if (slot_key[slot] == key) begin
            slot_val[slot] = val;
            r.status = ST_OK;
            break;
          end
          slot = (slot + 1) % TABLE_SLOTS;
        end
      end
    end else begin
      r.status = ST_MISSING;
      for (int p = 0; p < PROBE_DEPTH; p++) begin
        if (slot_used[slot] && slot_key[slot] == key) begin
          r.read_value = slot_val[slot];
          r.status     = ST_OK;
          break;
        end
        slot = (slot + 1) % TABLE_SLOTS;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < DIRECT_LIMIT; i++) direct_vals[i] = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_val[i]  = '0;
      end
      table_fill = 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_results.push_back(predict_map_op(in_mon.operation, in_mon.lookup_key,
                                                  in_mon.store_value));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: status %0d read_value %h",
                 out_mon.status, out_mon.read_value);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (out_mon.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_mon.status);
            errs++;
          end
          if (out_mon.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %h, actual %h",
                   want.read_value, out_mon.read_value);
            errs++;
          end
          case (want.status)
            ST_OK:      ok_count      <= ok_count + 1;
            ST_MISSING: missing_count <= missing_count + 1;
            default:    full_count    <= full_count + 1;
          endcase
        end
      end
    end
    fail_count      <= fail_count + errs;
    pending_count   <= expected_results.size();
    table_fill_seen <= table_fill;
  end

endmodule

// ===== bench/int_key_linear_probe_map_tb.sv =====
// ----------------------------------------------------------------------------
// int_key_linear_probe_map_tb
// Drives put and get transactions into the probe map: a directed pass over
// the direct array, collisions, wrap-around and probe exhaustion, then random
// traffic that fills the table up to its half-occupancy limit. Both channels
// idle in random bursts; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module int_key_linear_probe_map_tb import ilpm_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIRECT_LIMIT = 256;
  localparam int TABLE_SLOTS  = 256;
  localparam int RANDOM_ITEMS = 1025;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 250000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [31:0] cycle_count = '0;
  logic        steady_tail = 1'b0;
  int          stall_left  = 0;
  int          fail_count, pending_count, ok_count, missing_count, full_count;
  int          table_fill_seen;
  logic [KEY_W-1:0] known_keys [$];

  ilpm_in_if  in_ch ();
  ilpm_out_if out_ch ();

  int_key_linear_probe_map dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  probe_map_checker #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .DIRECT_LIMIT (DIRECT_LIMIT),
    .PROBE_DEPTH  (8)
  ) map_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .ok_count        (ok_count),
    .missing_count   (missing_count),
    .full_count      (full_count),
    .table_fill_seen (table_fill_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!steady_tail && cycle_count[8] && $urandom_range(0, 3) == 0) begin
      stall_left   <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [KEY_W-1:0] random_table_key();
    logic [KEY_W-1:0] k;
    k = $urandom;
    if (k < DIRECT_LIMIT) k[8] = 1'b1;
    return k;
  endfunction

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] val);
    int gap;
    gap = 0;
    if (!steady_tail && !cycle_count[9] && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.lookup_key  <= key;
    in_ch.store_value <= val;
    if (op == OP_PUT && key >= DIRECT_LIMIT) known_keys.push_back(key);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    logic             op;
    logic [KEY_W-1:0] key;
    logic [DATA_W-1:0] val;
    int               pick;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_PUT;
    in_ch.lookup_key  = '0;
    in_ch.store_value = '0;
    out_ch.ready      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(OP_GET, 32'd0,         32'h0);
    send_request(OP_GET, 32'd255,       32'hFFFF_FFFF);
    send_request(OP_PUT, 32'd0,         32'hFFFF_FFFF);
    send_request(OP_GET, 32'd0,         32'h0);
    send_request(OP_PUT, 32'd255,       32'h0000_0001);
    send_request(OP_GET, 32'd255,       32'h0);
    send_request(OP_PUT, 32'd255,       32'h0);
    send_request(OP_GET, 32'd255,       32'h0);
    send_request(OP_GET, 32'd256,       32'h0);
    send_request(OP_PUT, 32'd256,       32'hA5A5_A5A5);
    send_request(OP_PUT, 32'hFFFF_FF00, 32'h5A5A_5A5A);
    send_request(OP_GET, 32'hFFFF_FF00, 32'h0);
    send_request(OP_PUT, 32'd256,       32'h0);
    send_request(OP_GET, 32'd256,       32'h1234_5678);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(OP_PUT, 32'h0000_01FF, 32'h8765_4321);
    send_request(OP_GET, 32'h0000_01FF, 32'h0);
    send_request(OP_GET, 32'h0000_02FF, 32'h0);
    for (int k = 3; k <= 7; k++)
      send_request(OP_PUT, 32'(k) << 8, $urandom);
    send_request(OP_PUT, 32'h0000_0800, 32'hDEAD_BEEF);
    send_request(OP_GET, 32'h0000_0800, 32'h0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      if (pick < 25) begin
        op  = OP_GET;
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < 40) begin
        op  = OP_PUT;
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (pick < 50) begin
        op  = OP_PUT;
        key = {24'($urandom_range(1, 24'hFF_FFFF)), 8'(244 + $urandom_range(0, 23))};
      end else if (pick < 58) begin
        op  = OP_PUT;
        key = random_table_key();
      end else if (pick < 68) begin
        op  = OP_GET;
        key = random_table_key();
      end else if (pick < 88) begin
        op  = 1'($urandom_range(0, 1));
        key = $urandom_range(0, DIRECT_LIMIT - 1);
      end else begin
        op  = 1'($urandom_range(0, 1));
        key = $urandom;
      end
      send_request(op, key, val);
    end

    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results: %0d ok, %0d key missing, %0d table full",
             ok_count + missing_count + full_count, ok_count, missing_count, full_count);
    $display("Hash table ended with %0d of %0d slots in use", table_fill_seen, TABLE_SLOTS);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
